/* sv/lem_pkg.sv */
// ----------------------------------------------------------------------------
// lem_pkg: shared types and constants of the Laplacian edge magnitude core
// Register indexes, operation classes, queue control word and operand slots.
// ----------------------------------------------------------------------------
package lem_pkg;

	localparam int MAX_COLS_DEF   = 2048;
	localparam int PIXEL_BITS_DEF = 8;

	localparam int EDGE_W      = 10;
	localparam int COLS_CFG_W  = 12;
	localparam int ROWS_W      = 16;
	localparam int CFG_DATA_W  = 16;

	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 12'd640;
	localparam logic [ROWS_W-1:0]     ROWS_RESET = 16'd480;

	// Smallest image side that gets the stencil; smaller images pass through.
	localparam int MIN_SIZE     = 3;
	// The centre weight of four is a shift by two.
	localparam int CENTRE_SHIFT = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	// Operand slots of one queue entry, each PIXEL_BITS wide.
	localparam int NUM_SLOTS  = 5;
	localparam int SLOT_LEFT  = 0;
	localparam int SLOT_UP    = 1;
	localparam int SLOT_RIGHT = 2;
	localparam int SLOT_ABOVE = 3;
	localparam int SLOT_PIX   = 4;

	typedef enum logic [0:0] {
		CFG_COLS = 1'b0,
		CFG_ROWS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_VERT,
		OP_LEFT,
		OP_RIGHT,
		OP_INNER
	} op_t;

	typedef struct packed {
		op_t  op;
		logic second;
		logic last;
	} ctl_t;

endpackage

/* sv/laplacian_edge_magnitude_core.sv */
// ----------------------------------------------------------------------------
// laplacian_edge_magnitude_core: streaming absolute 4-neighbour Laplacian
// Pixels enter in raster order; edge magnitudes leave one row later.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on pixel with in_valid; a request is taken on a clock edge
// where in_valid is high and in_stall is low. Results leave on edge_value and
// frame_last with out_valid and are taken when out_stall is low.
// The configuration port writes image_cols (index 0) and image_rows (index 1)
// with cfg_valid; cfg_ready is always high. Write it only while the core is
// idle.
// The result for row r-1 leaves when the pixel in the same column of row r is
// taken, after the read stage, the queue and the result register. Every pixel
// of the last row yields two results, the second being its own. Images narrower
// or shorter than three pass pixels straight through the same path.
// Throughput is one pixel per clock while out_stall is low; a last-row pixel
// holds the queue head until the result register sent both results. The line
// stores are three single-port-read RAMs read every cycle and written in the
// cycle after the read. Reset sets the size to 640 by 480 and the position to
// the frame start; the line stores need no clearing. With out_stall held, the
// result register fills; in_stall rises at four in the queue and read stage.
// ----------------------------------------------------------------------------
module laplacian_edge_magnitude_core #(
	parameter int MAX_COLS   = lem_pkg::MAX_COLS_DEF,
	parameter int PIXEL_BITS = lem_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  lem_pkg::cfg_idx_t              cfg_index,
	input  logic [lem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PIXEL_BITS-1:0]          pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lem_pkg::EDGE_W-1:0]     edge_value,
	output logic                           frame_last
);

	localparam int DATA_W = lem_pkg::NUM_SLOTS * PIXEL_BITS;

	logic                        push, pop, q_empty;
	lem_pkg::ctl_t               push_ctl, head_ctl;
	logic [DATA_W-1:0]           push_data, head_data;
	logic [lem_pkg::LEVEL_W-1:0] q_level;

	lem_front #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.q_level   (q_level),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_data (push_data)
	);

	lem_queue #(.WIDTH(DATA_W), .DEPTH(lem_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_data (push_data),
		.pop       (pop),
		.empty     (q_empty),
		.head_ctl  (head_ctl),
		.head_data (head_data),
		.level     (q_level)
	);

	lem_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head_ctl   (head_ctl),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_value (edge_value),
		.frame_last (frame_last)
	);

endmodule

/* sv/lem_ram.sv */
// ----------------------------------------------------------------------------
// lem_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered, read-first.
// ----------------------------------------------------------------------------
module lem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/lem_front.sv */
// ----------------------------------------------------------------------------
// lem_front: request intake, line stores and classification
// Tracks the raster position, reads and updates the two line stores, and
// hands each request that yields results to the queue with its operands.
// ----------------------------------------------------------------------------
module lem_front #(
	parameter int MAX_COLS   = lem_pkg::MAX_COLS_DEF,
	parameter int PIXEL_BITS = lem_pkg::PIXEL_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  lem_pkg::cfg_idx_t                         cfg_index,
	input  logic [lem_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [PIXEL_BITS-1:0]                     pixel,
	input  logic [lem_pkg::LEVEL_W-1:0]               q_level,
	output logic                                      push,
	output lem_pkg::ctl_t                             push_ctl,
	output logic [lem_pkg::NUM_SLOTS*PIXEL_BITS-1:0]  push_data
);

	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int CMP_W  = (ADDR_W + 1 > lem_pkg::COLS_CFG_W) ? ADDR_W + 1
	                                                           : lem_pkg::COLS_CFG_W;
	localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
	localparam int USED_W = lem_pkg::LEVEL_W + 1;

	logic [lem_pkg::COLS_CFG_W-1:0] image_cols_q;
	logic [lem_pkg::ROWS_W-1:0]     image_rows_q;
	logic [ADDR_W-1:0]              col_cnt_q;
	logic [lem_pkg::ROWS_W-1:0]     row_cnt_q;

	logic [CMP_W-1:0]           cols_raw, cols_eff, col_full, col_inc;
	logic [lem_pkg::ROWS_W-1:0] rows_eff, rows_m1;
	logic [ADDR_W-1:0]          col, col_next;
	logic                       wrap, last_row, last_pix, bypass, emit_d, accept;
	lem_pkg::ctl_t              ctl_d;
	logic [USED_W-1:0]          used;

	logic                  s1_valid_q;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [ADDR_W-1:0]     col_s1;
	lem_pkg::ctl_t         ctl_s1;
	logic                  emit_s1;
	logic                  fwd_a_s1, fwd_b_s1, fwd_o_s1;
	logic [PIXEL_BITS-1:0] fwd_pix_s1, fwd_above_s1;
	logic [PIXEL_BITS-1:0] left_q;

	logic [PIXEL_BITS-1:0] newer_a_rd, newer_b_rd, older_rd;
	logic [PIXEL_BITS-1:0] above, right, up;

	assign cfg_ready = 1'b1;

	// Effective image size: zero counts as one, columns saturate at the store depth.
	assign cols_raw = CMP_W'(image_cols_q);
	always_comb begin
		priority if (cols_raw == '0) begin
			cols_eff = CMP_W'(1);
		end else if (cols_raw > MAX_COLS_C) begin
			cols_eff = MAX_COLS_C;
		end else begin
			cols_eff = cols_raw;
		end
	end
	assign rows_eff = (image_rows_q == '0) ? lem_pkg::ROWS_W'(1) : image_rows_q;
	assign rows_m1  = rows_eff - lem_pkg::ROWS_W'(1);

	// A column count left beyond a shrunk width is held at the last column.
	assign col_full = (CMP_W'(col_cnt_q) >= cols_eff) ? cols_eff - CMP_W'(1)
	                                                 : CMP_W'(col_cnt_q);
	assign col      = col_full[ADDR_W-1:0];
	assign col_inc  = col_full + CMP_W'(1);
	assign wrap     = (col_inc >= cols_eff);
	assign col_next = wrap ? '0 : col_inc[ADDR_W-1:0];
	assign last_row = (row_cnt_q >= rows_m1);
	assign last_pix = last_row && wrap;
	assign bypass   = (cols_eff < CMP_W'(lem_pkg::MIN_SIZE)) ||
	                  (rows_eff < lem_pkg::ROWS_W'(lem_pkg::MIN_SIZE));

	always_comb begin
		priority if (bypass) begin
			ctl_d.op = lem_pkg::OP_PASS;
		end else if (row_cnt_q == lem_pkg::ROWS_W'(1)) begin
			ctl_d.op = lem_pkg::OP_VERT;
		end else if (col == '0) begin
			ctl_d.op = lem_pkg::OP_LEFT;
		end else if (wrap) begin
			ctl_d.op = lem_pkg::OP_RIGHT;
		end else begin
			ctl_d.op = lem_pkg::OP_INNER;
		end
		ctl_d.second = !bypass && last_row;
		ctl_d.last   = last_pix;
	end
	assign emit_d = bypass || (row_cnt_q != '0);

	// Room is reserved for the request in the read stage as well as the new one.
	assign used     = USED_W'(q_level) + USED_W'(s1_valid_q);
	assign in_stall = (used >= USED_W'(lem_pkg::QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= lem_pkg::COLS_RESET;
			image_rows_q <= lem_pkg::ROWS_RESET;
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lem_pkg::CFG_COLS: image_cols_q <= cfg_data[lem_pkg::COLS_CFG_W-1:0];
					lem_pkg::CFG_ROWS: image_rows_q <= cfg_data[lem_pkg::ROWS_W-1:0];
				endcase
			end
			if (accept) begin
				col_cnt_q <= col_next;
				if (wrap) begin
					row_cnt_q <= last_row ? '0 : row_cnt_q + lem_pkg::ROWS_W'(1);
				end
			end
			s1_valid_q <= accept;
		end
	end

	// The line stores are written in the cycle after the read. A read that meets
	// that write at the same address takes the data being written instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			col_s1  <= col;
			ctl_s1  <= ctl_d;
			emit_s1 <= emit_d;
		end
		fwd_a_s1     <= s1_valid_q && (col_s1 == col);
		fwd_b_s1     <= s1_valid_q && (col_s1 == col_next);
		fwd_o_s1     <= s1_valid_q && (col_s1 == col);
		fwd_pix_s1   <= pix_s1;
		fwd_above_s1 <= above;
		if (s1_valid_q) begin
			left_q <= above;
		end
	end

	lem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_newer_a (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (col_s1),
		.wdata (pix_s1),
		.raddr (col),
		.rdata (newer_a_rd)
	);

	lem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_newer_b (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (col_s1),
		.wdata (pix_s1),
		.raddr (col_next),
		.rdata (newer_b_rd)
	);

	lem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_older (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (col_s1),
		.wdata (above),
		.raddr (col),
		.rdata (older_rd)
	);

	assign above = fwd_a_s1 ? fwd_pix_s1 : newer_a_rd;
	assign right = fwd_b_s1 ? fwd_pix_s1 : newer_b_rd;
	assign up    = fwd_o_s1 ? fwd_above_s1 : older_rd;

	assign push     = s1_valid_q && emit_s1;
	assign push_ctl = ctl_s1;
	always_comb begin
		push_data = '0;
		push_data[lem_pkg::SLOT_PIX*PIXEL_BITS   +: PIXEL_BITS] = pix_s1;
		push_data[lem_pkg::SLOT_ABOVE*PIXEL_BITS +: PIXEL_BITS] = above;
		push_data[lem_pkg::SLOT_RIGHT*PIXEL_BITS +: PIXEL_BITS] = right;
		push_data[lem_pkg::SLOT_UP*PIXEL_BITS    +: PIXEL_BITS] = up;
		push_data[lem_pkg::SLOT_LEFT*PIXEL_BITS  +: PIXEL_BITS] = left_q;
	end

`ifndef SYNTH
	a_s1_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $past(accept))
		else $error("read stage holds a request that was never accepted");
`endif

endmodule

/* sv/lem_queue.sv */
// ----------------------------------------------------------------------------
// lem_queue: short queue between the front and back parts
// Holds classified requests with their operands until the back part takes them.
// ----------------------------------------------------------------------------
module lem_queue #(
	parameter int WIDTH = 40,
	parameter int DEPTH = lem_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lem_pkg::ctl_t                push_ctl,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic                         empty,
	output lem_pkg::ctl_t                head_ctl,
	output logic [WIDTH-1:0]             head_data,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lem_pkg::ctl_t    ctl_q  [DEPTH];
	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	assign empty     = (count_q == '0);
	assign head_ctl  = ctl_q[rd_ptr_q];
	assign head_data = data_q[rd_ptr_q];
	assign level     = count_q;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)))
		else $error("request queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("request queue read while empty");
`endif

endmodule

/* sv/lem_back.sv */
// ----------------------------------------------------------------------------
// lem_back: stencil arithmetic and result register
// Works out the magnitude for the queue head and delivers one or two results.
// ----------------------------------------------------------------------------
module lem_back #(
	parameter int PIXEL_BITS = lem_pkg::PIXEL_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     empty,
	input  lem_pkg::ctl_t                            head_ctl,
	input  logic [lem_pkg::NUM_SLOTS*PIXEL_BITS-1:0] head_data,
	output logic                                     pop,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [lem_pkg::EDGE_W-1:0]               edge_value,
	output logic                                     frame_last
);

	localparam int WW = (PIXEL_BITS + 2 > lem_pkg::EDGE_W) ? PIXEL_BITS + 2
	                                                       : lem_pkg::EDGE_W;

	logic [PIXEL_BITS-1:0] pix, above, right, up, left;
	logic [WW-1:0]         sum_w, a_w, b_w, diff_w, res_w;
	logic                  load, take, phase_q, out_valid_q;
	logic [lem_pkg::EDGE_W-1:0] edge_value_q;
	logic                  frame_last_q, frame_last_d;

	assign pix   = head_data[lem_pkg::SLOT_PIX*PIXEL_BITS   +: PIXEL_BITS];
	assign above = head_data[lem_pkg::SLOT_ABOVE*PIXEL_BITS +: PIXEL_BITS];
	assign right = head_data[lem_pkg::SLOT_RIGHT*PIXEL_BITS +: PIXEL_BITS];
	assign up    = head_data[lem_pkg::SLOT_UP*PIXEL_BITS    +: PIXEL_BITS];
	assign left  = head_data[lem_pkg::SLOT_LEFT*PIXEL_BITS  +: PIXEL_BITS];

	assign sum_w = WW'(pix) + WW'(up) + WW'(right) + WW'(left);

	// The second result of a last-row request is the difference to the row above.
	always_comb begin
		a_w = WW'(above);
		b_w = WW'(pix);
		if (!phase_q) begin
			unique case (head_ctl.op)
				lem_pkg::OP_VERT:  b_w = WW'(pix);
				lem_pkg::OP_LEFT:  b_w = WW'(right);
				lem_pkg::OP_RIGHT: b_w = WW'(left);
				lem_pkg::OP_INNER: begin
					a_w = WW'(above) << lem_pkg::CENTRE_SHIFT;
					b_w = sum_w;
				end
				lem_pkg::OP_PASS:  b_w = WW'(pix);
				default:           b_w = WW'(pix);
			endcase
		end
	end

	assign diff_w = (a_w >= b_w) ? a_w - b_w : b_w - a_w;
	assign res_w  = (head_ctl.op == lem_pkg::OP_PASS) ? WW'(pix) : diff_w;
	assign frame_last_d = head_ctl.last &&
	                      (phase_q || (head_ctl.op == lem_pkg::OP_PASS));

	assign load = !out_valid_q || !out_stall;
	assign take = load && !empty;
	assign pop  = take && !(head_ctl.second && !phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= take;
			end
			if (take) begin
				phase_q <= head_ctl.second && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			edge_value_q <= res_w[lem_pkg::EDGE_W-1:0];
			frame_last_q <= frame_last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_value_q;
	assign frame_last = frame_last_q;

`ifndef SYNTH
	a_phase_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!empty && head_ctl.second))
		else $error("second result pending without a two-result request at the head");
`endif

endmodule
